### sv/aes_ctr_pkg.sv
// Shared types, constants and AES helper functions for the counter-mode keystream block.
package aes_ctr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;
    localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [2:0] REG_NONCE_LOW  = 3'd6;

    // Key size codes; the unused code acts as a 128-bit key.
    localparam logic [1:0] KEY_128 = 2'd0;
    localparam logic [1:0] KEY_192 = 2'd1;
    localparam logic [1:0] KEY_256 = 2'd2;

    // Depth of the keystream block queue.
    localparam int Q_DEPTH = 2;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Status of the key expansion, seen by the keystream generator.
    typedef struct packed {
        logic       done;
        logic [3:0] nr;
    } kexp_status_t;

    // Status of the block queue.
    typedef struct packed {
        logic               nonempty;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Round constant for a given word-group index.
    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round without the round key: SubBytes, ShiftRows and, unless last, MixColumns.
    // Byte k of the state sits at bits 127-8k down.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3, al;
        int           r, c;
        for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
                t[r + 4 * c] = sbox(s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]);
            end
        end
        for (c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (last) begin
                o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127 - 32 * c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                         a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
            end
        end
        return o;
    endfunction

endpackage

### sv/aes_ctr_kexp.sv
// Key expansion unit: one round-key word per cycle into a round-key register file.
module aes_ctr_kexp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic [1:0]                 key_size,
    input  logic [255:0]               key,
    input  logic [3:0]                 rd_idx,
    output logic [127:0]               rd_key,
    output aes_ctr_pkg::kexp_status_t  status
);

    logic [3:0][31:0] rk_reg [15];
    logic [31:0]      win_reg [8];
    logic [5:0]       cnt_reg, cnt_next;
    logic [2:0]       mod_reg, mod_next;
    logic [3:0]       rci_reg, rci_next;
    logic             busy_reg, busy_next;
    logic [3:0]       nk, nr;
    logic [5:0]       total;
    logic [31:0]      t, new_word;

    // Key geometry from the key size code.
    always_comb
    begin
        case (key_size)
            aes_ctr_pkg::KEY_192: nk = 4'd6;
            aes_ctr_pkg::KEY_256: nk = 4'd8;
            default:              nk = 4'd4;
        endcase
        nr    = nk + 4'd6;
        total = {nr, 2'b00} + 6'd4;
    end

    // Next expanded word, from the key itself or from the sliding window.
    always_comb
    begin
        t = win_reg[7];
        if (mod_reg == 3'd0) begin
            t = aes_ctr_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                ^ {aes_ctr_pkg::rcon(rci_reg), 24'h0};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t = aes_ctr_pkg::sub_word(win_reg[7]);
        end
        if (cnt_reg < {2'b00, nk}) begin
            new_word = key[8'd255 - {cnt_reg[2:0], 5'd0} -: 32];
        end else begin
            new_word = win_reg[3'(4'd8 - nk)] ^ t;
        end
    end

    // Counters that track the word index, its position in the key group and the group number.
    always_comb
    begin
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        rci_next  = rci_reg;
        busy_next = busy_reg;
        if (restart) begin
            cnt_next  = 6'd0;
            mod_next  = 3'd0;
            rci_next  = 4'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if ({1'b0, mod_reg} == nk - 4'd1) begin
                mod_next = 3'd0;
                rci_next = rci_reg + 4'd1;
            end else begin
                mod_next = mod_reg + 3'd1;
            end
            if (cnt_reg == total - 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= 6'd0;
            mod_reg  <= 3'd0;
            rci_reg  <= 4'd0;
            busy_reg <= 1'b1;
        end else begin
            cnt_reg  <= cnt_next;
            mod_reg  <= mod_next;
            rci_reg  <= rci_next;
            busy_reg <= busy_next;
        end
    end

    // Window of the last eight words and the round-key file.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !restart) begin
            for (int i = 0; i < 7; i++) begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[7] <= new_word;
            rk_reg[cnt_reg[5:2]][2'd3 - cnt_reg[1:0]] <= new_word;
        end
    end

    assign rd_key      = rk_reg[rd_idx];
    assign status.done = !busy_reg;
    assign status.nr   = nr;

endmodule

### sv/aes_ctr_gen.sv
// Keystream generator: counter block build and iterative AES rounds, one round per cycle.
module aes_ctr_gen (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic [63:0]                nonce_high,
    input  logic [31:0]                nonce_low,
    input  aes_ctr_pkg::kexp_status_t  kstat,
    input  logic [127:0]               rk,
    output logic [3:0]                 rk_idx,
    input  aes_ctr_pkg::q_status_t     qstat,
    output logic                       push,
    output logic [127:0]               push_data
);

    logic [31:0]  ctr_reg, ctr_next;
    logic [127:0] st_reg, st_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         launch, last;

    // Start a block only when a queue slot is free for it.
    assign launch = !busy_reg && kstat.done && !restart
                    && (qstat.count < aes_ctr_pkg::Q_CNT_W'(aes_ctr_pkg::Q_DEPTH));
    assign rk_idx = busy_reg ? rnd_reg : 4'd0;
    assign last   = (rnd_reg == kstat.nr);

    // Round datapath.
    always_comb
    begin
        push_data = aes_ctr_pkg::aes_round(st_reg, last) ^ rk;
        push      = busy_reg && last && !restart;
    end

    always_comb
    begin
        ctr_next  = ctr_reg;
        st_next   = st_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        if (restart) begin
            ctr_next  = 32'd1;
            busy_next = 1'b0;
        end else if (launch) begin
            st_next   = {nonce_high, nonce_low, ctr_reg} ^ rk;
            rnd_next  = 4'd1;
            busy_next = 1'b1;
            ctr_next  = ctr_reg + 32'd1;
        end else if (busy_reg) begin
            st_next  = push_data;
            rnd_next = rnd_reg + 4'd1;
            if (last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctr_reg  <= 32'd1;
            rnd_reg  <= 4'd0;
            busy_reg <= 1'b0;
        end else begin
            ctr_reg  <= ctr_next;
            rnd_reg  <= rnd_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

endmodule

### sv/aes_ctr_fifo.sv
// Short queue of finished keystream blocks between the generator and the byte stage.
module aes_ctr_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    flush,
    input  logic                    push,
    input  logic [127:0]            push_data,
    input  logic                    pop,
    output logic [127:0]            head,
    output aes_ctr_pkg::q_status_t  status
);

    localparam int PW = aes_ctr_pkg::Q_PTR_W;
    localparam int CW = aes_ctr_pkg::Q_CNT_W;

    logic [127:0]  mem_reg [aes_ctr_pkg::Q_DEPTH];
    logic [PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (flush) begin
            wr_next  = '0;
            rd_next  = '0;
            cnt_next = '0;
        end else begin
            if (push) begin
                wr_next = (wr_reg == PW'(aes_ctr_pkg::Q_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_next = (rd_reg == PW'(aes_ctr_pkg::Q_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
            cnt_next = cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !flush) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign head            = mem_reg[rd_reg];
    assign status.nonempty = (cnt_reg != '0);
    assign status.count    = cnt_reg;

endmodule

### sv/aes_ctr_xor.sv
// Byte stage: combines each input byte with the next keystream byte into an output register.
module aes_ctr_xor (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    restart,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              plain_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              cipher_byte,
    input  logic [127:0]            head,
    input  aes_ctr_pkg::q_status_t  qstat,
    output logic                    pop
);

    logic [3:0] pos_reg, pos_next;
    logic       ov_reg, ov_next;
    logic [7:0] data_reg;
    logic [6:0] base;
    logic       accept;

    // Accept while a block is queued and the output register is free or draining.
    assign in_ready = qstat.nonempty && (!ov_reg || out_ready) && !restart;
    assign accept   = in_valid && in_ready;
    assign pop      = accept && (pos_reg == 4'hf);
    assign base     = {~pos_reg, 3'b000};

    always_comb
    begin
        pos_next = pos_reg;
        ov_next  = ov_reg;
        if (restart) begin
            pos_next = 4'd0;
            ov_next  = 1'b0;
        end else if (accept) begin
            pos_next = pos_reg + 4'd1;
            ov_next  = 1'b1;
        end else if (out_ready) begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 4'd0;
            ov_reg  <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            data_reg <= plain_byte ^ head[base +: 8];
        end
    end

    assign out_valid   = ov_reg;
    assign cipher_byte = data_reg;

endmodule

### sv/aes_ctr_keystream_xor.sv
// Top level of the AES counter-mode keystream XOR block with its configuration registers.
//
//   Channel   Signals                                   Direction
//   input     in_valid, in_ready, plain_byte            byte in
//   output    out_valid, out_ready, cipher_byte         byte out
//   config    cfg_we, cfg_index, cfg_data               register write, no handshake
//
// Sustained rate is one byte per cycle while out_ready is high. Keystream blocks are built
// round by round in the shared round unit (128, 192, 256-bit keys), and the generator stays
// ahead of the byte stage. After reset or a write to a known register, key expansion runs
// and the first block follows; no byte is accepted until that block is queued.
// A two-block queue separates generator and byte stage, so either side can stall alone.
module aes_ctr_keystream_xor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  plain_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cipher_byte
);

    logic [1:0]                 key_size_reg;
    logic [63:0]                key_reg [4];
    logic [63:0]                nonce_high_reg;
    logic [31:0]                nonce_low_reg;
    logic                       restart;
    logic [3:0]                 rk_idx;
    logic [127:0]               rk;
    aes_ctr_pkg::kexp_status_t  kstat;
    aes_ctr_pkg::q_status_t     qstat;
    logic                       push, pop;
    logic [127:0]               push_data, head;

    // Any write to a known register restarts the stream.
    assign restart = cfg_we && (cfg_index <= aes_ctr_pkg::REG_NONCE_LOW);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_size_reg   <= 2'd0;
            key_reg[0]     <= 64'd0;
            key_reg[1]     <= 64'd0;
            key_reg[2]     <= 64'd0;
            key_reg[3]     <= 64'd0;
            nonce_high_reg <= 64'd0;
            nonce_low_reg  <= 32'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                aes_ctr_pkg::REG_KEY_SIZE:   key_size_reg   <= cfg_data[1:0];
                aes_ctr_pkg::REG_KEY_WORD_0: key_reg[0]     <= cfg_data;
                aes_ctr_pkg::REG_KEY_WORD_1: key_reg[1]     <= cfg_data;
                aes_ctr_pkg::REG_KEY_WORD_2: key_reg[2]     <= cfg_data;
                aes_ctr_pkg::REG_KEY_WORD_3: key_reg[3]     <= cfg_data;
                aes_ctr_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data;
                aes_ctr_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data[31:0];
                default:                     ;
            endcase
        end
    end

    aes_ctr_kexp u_kexp (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .key_size (key_size_reg),
        .key      ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .rd_idx   (rk_idx),
        .rd_key   (rk),
        .status   (kstat)
    );

    aes_ctr_gen u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .nonce_high (nonce_high_reg),
        .nonce_low  (nonce_low_reg),
        .kstat      (kstat),
        .rk         (rk),
        .rk_idx     (rk_idx),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    aes_ctr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (restart),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (qstat)
    );

    aes_ctr_xor u_xor (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .plain_byte  (plain_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cipher_byte (cipher_byte),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop)
    );

endmodule

### dv/aes_ctr_keystream_xor_tb.sv
// Testbench for the AES counter-mode keystream XOR block against a software AES-CTR predictor.
module aes_ctr_keystream_xor_tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  plain_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  cipher_byte;

    aes_ctr_keystream_xor u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
        .plain_byte(plain_byte), .out_valid(out_valid), .out_ready(out_ready),
        .cipher_byte(cipher_byte)
    );

    // Predictor copy of the registers and stream state.
    logic [1:0]   km_key_size;
    logic [63:0]  km_key [4];
    logic [63:0]  km_nonce_hi;
    logic [31:0]  km_nonce_lo;
    logic [31:0]  km_counter;
    logic [127:0] km_block;
    logic [3:0]   km_pos;
    logic [31:0]  km_rk [60];
    int           km_rounds;

    logic [7:0] pending_bytes[$];
    logic [7:0] expected_cipher[$];
    int         err_count;
    bit         feeding_done;
    int         hold_off;
    int         hold_req_seq;
    int         hold_req_len;
    int         hold_ack_seq;

    // S-box from the package lookup table, not its helper functions.
    function automatic logic [31:0] sw(input logic [31:0] w);
        return {aes_ctr_pkg::SBOX[w[31:24]], aes_ctr_pkg::SBOX[w[23:16]],
                aes_ctr_pkg::SBOX[w[15:8]], aes_ctr_pkg::SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Key schedule per FIPS-197 for the configured key length.
    task automatic expand_schedule();
        int nk;
        int total;
        logic [31:0] t;
        logic [7:0] rc;
        nk = (km_key_size == aes_ctr_pkg::KEY_192) ? 6 :
             (km_key_size == aes_ctr_pkg::KEY_256) ? 8 : 4;
        km_rounds = nk + 6;
        total = 4 * (km_rounds + 1);
        for (int i = 0; i < nk; i++)
            km_rk[i] = i[0] ? km_key[i / 2][31:0] : km_key[i / 2][63:32];
        rc = 8'h01;
        for (int i = nk; i < total; i++) begin
            t = km_rk[i - 1];
            if (i % nk == 0) begin
                t = sw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sw(t);
            end
            km_rk[i] = km_rk[i - nk] ^ t;
        end
    endtask

    function automatic logic [127:0] encrypt_block(input logic [127:0] din);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int k = 0; k < 16; k++) s[k] = din[127 - 8 * k -: 8];
        for (int rnd = 0; rnd <= km_rounds; rnd++) begin
            if (rnd > 0) begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        t[r + 4 * c] = aes_ctr_pkg::SBOX[s[r + 4 * ((c + r) % 4)]];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    if (rnd == km_rounds) begin
                        s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
                    end else begin
                        al = a0 ^ a1 ^ a2 ^ a3;
                        s[4 * c]     = a0 ^ al ^ gmul2(a0 ^ a1);
                        s[4 * c + 1] = a1 ^ al ^ gmul2(a1 ^ a2);
                        s[4 * c + 2] = a2 ^ al ^ gmul2(a2 ^ a3);
                        s[4 * c + 3] = a3 ^ al ^ gmul2(a3 ^ a0);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int b = 0; b < 4; b++)
                    s[4 * c + b] ^= km_rk[rnd * 4 + c][31 - 8 * b -: 8];
        end
        for (int k = 0; k < 16; k++) o[127 - 8 * k -: 8] = s[k];
        return o;
    endfunction

    task automatic restart_stream();
        expand_schedule();
        km_counter = 32'd1;
        km_pos = 4'd0;
        km_block = encrypt_block({km_nonce_hi, km_nonce_lo, km_counter});
    endtask

    // Predict one output byte and advance the stream.
    task automatic predict_cipher(input logic [7:0] b);
        expected_cipher.push_back(b ^ km_block[127 - 8 * km_pos -: 8]);
        km_pos = km_pos + 4'd1;
        if (km_pos == 4'd0) begin
            km_counter = km_counter + 32'd1;
            km_block = encrypt_block({km_nonce_hi, km_nonce_lo, km_counter});
        end
    endtask

    // Write one register on the block and in the predictor; only called while idle.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            aes_ctr_pkg::REG_KEY_SIZE:   km_key_size = val[1:0];
            aes_ctr_pkg::REG_KEY_WORD_0: km_key[0] = val;
            aes_ctr_pkg::REG_KEY_WORD_1: km_key[1] = val;
            aes_ctr_pkg::REG_KEY_WORD_2: km_key[2] = val;
            aes_ctr_pkg::REG_KEY_WORD_3: km_key[3] = val;
            aes_ctr_pkg::REG_NONCE_HIGH: km_nonce_hi = val;
            aes_ctr_pkg::REG_NONCE_LOW:  km_nonce_lo = val[31:0];
            default: ;
        endcase
        if (idx <= aes_ctr_pkg::REG_NONCE_LOW) restart_stream();
    endtask

    // Wait for the stream to drain; the block then refills its queue on its own.
    task automatic wait_idle();
        do begin
            while (pending_bytes.size() != 0 || expected_cipher.size() != 0 || in_valid)
                @(posedge clk);
            repeat (20) @(posedge clk);
        end while (pending_bytes.size() != 0 || expected_cipher.size() != 0 || in_valid);
    endtask

    // Ask the receiver to hold off for a number of cycles.
    task automatic request_hold(input int cycles);
        hold_req_len = cycles;
        hold_req_seq = hold_req_seq + 1;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Driver: bursts of random length with random gaps between them.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            plain_byte <= 8'h00;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ready) predict_cipher(plain_byte);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    in_valid <= 1'b1;
                    plain_byte <= pending_bytes.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles once requested.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_off <= 0;
            hold_ack_seq <= 0;
        end else if (hold_ack_seq != hold_req_seq) begin
            hold_off <= hold_req_len;
            hold_ack_seq <= hold_req_seq;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    // Monitor and receiver stall pattern.
    int stall_phase;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_cipher.size() == 0) begin
                    $display("%0t: unexpected cipher_byte %h", $time, cipher_byte);
                    err_count++;
                end else begin
                    if (cipher_byte !== expected_cipher[0]) begin
                        $display("%0t: cipher_byte expected %h actual %h", $time,
                                 expected_cipher[0], cipher_byte);
                        err_count++;
                    end
                    void'(expected_cipher.pop_front());
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (hold_off > 0) begin
                out_ready <= 1'b0;
            end else if (stall_phase < 30) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= (($urandom_range(0, 3) != 0) && (stall_phase % 11 != 3));
            end
        end
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [1:0] ks;
        int n;
        err_count = 0;
        hold_req_seq = 0;
        hold_req_len = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aes_ctr_pkg::REG_KEY_SIZE;
        cfg_data = 64'h0;
        km_key_size = aes_ctr_pkg::KEY_128;
        for (int i = 0; i < 4; i++) km_key[i] = 64'h0;
        km_nonce_hi = 64'h0;
        km_nonce_lo = 32'h0;
        restart_stream();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero key stream with extreme bytes, spanning a block boundary.
        for (int i = 0; i < 20; i++)
            pending_bytes.push_back((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hff : 8'ha5);
        wait_idle();

        // Directed: FIPS-197 128-bit key, all-ones nonce, receiver held off long.
        write_reg(aes_ctr_pkg::REG_KEY_WORD_0, 64'h0001020304050607);
        write_reg(aes_ctr_pkg::REG_KEY_WORD_1, 64'h08090a0b0c0d0e0f);
        write_reg(aes_ctr_pkg::REG_NONCE_HIGH, 64'hffffffffffffffff);
        write_reg(aes_ctr_pkg::REG_NONCE_LOW, 64'hffffffff);
        request_hold(300);
        for (int i = 0; i < 60; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
        wait_idle();

        // Key sizes: 128, 192, 256 and the unused code, with extreme key words.
        write_reg(aes_ctr_pkg::REG_KEY_WORD_2, 64'hffffffffffffffff);
        write_reg(aes_ctr_pkg::REG_KEY_WORD_3, 64'h0);
        for (int k = 0; k < 4; k++) begin
            write_reg(aes_ctr_pkg::REG_KEY_SIZE, {62'h0, k[1:0]});
            for (int i = 0; i < 24; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
            wait_idle();
        end

        // An unknown register index must leave the stream running.
        write_reg(3'd7, rand64());
        for (int i = 0; i < 8; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
        wait_idle();

        // Random phases with random key, nonce and size.
        for (int ph = 0; ph < 12; ph++) begin
            ks = 2'($urandom_range(0, 3));
            write_reg(aes_ctr_pkg::REG_KEY_SIZE, {62'h0, ks});
            for (int i = 0; i < 4; i++)
                write_reg(aes_ctr_pkg::REG_KEY_WORD_0 + i[2:0], rand64());
            write_reg(aes_ctr_pkg::REG_NONCE_HIGH, rand64());
            write_reg(aes_ctr_pkg::REG_NONCE_LOW, {32'h0, $urandom});
            if (ph == 5) request_hold(200);
            n = $urandom_range(100, 160);
            for (int i = 0; i < n; i++) pending_bytes.push_back(8'($urandom_range(0, 255)));
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (err_count == 0 && expected_cipher.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
sv/aes_ctr_pkg.sv
sv/aes_ctr_kexp.sv
sv/aes_ctr_gen.sv
sv/aes_ctr_fifo.sv
sv/aes_ctr_xor.sv
sv/aes_ctr_keystream_xor.sv
dv/aes_ctr_keystream_xor_tb.sv
